// File: rtl/pws_pkg.sv
// Shared constants and types for the perspective world-to-screen unit.
// No dependencies; used by the interfaces, the divider step and the top level.
package pws_pkg;

   localparam int SCREEN_WIDTH  = 1920;
   localparam int SCREEN_HEIGHT = 1080;
   localparam int HALF_W        = SCREEN_WIDTH / 2;
   localparam int HALF_H        = SCREEN_HEIGHT / 2;

   localparam int COORD_W    = 32;
   localparam int PROD_W     = 64;
   localparam int CLIP_W     = 50;
   localparam int NUM_W      = 64;
   localparam int Q_W        = 16;
   localparam int DIV_STEPS  = Q_W;
   localparam int REM_W      = NUM_W + 2;
   localparam int PIX_W      = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;
   localparam int MAT_REGS   = 6;
   localparam int STAGES     = DIV_STEPS + 5;

   localparam logic signed [CLIP_W-1:0] W_VISIBLE_MIN = CLIP_W'(6554);
   localparam logic signed [NUM_W-1:0]  X_MUL  = NUM_W'(HALF_W + 1);
   localparam logic signed [NUM_W-1:0]  X_OFF  = NUM_W'(HALF_W);
   localparam logic signed [NUM_W-1:0]  Y_MUL  = NUM_W'(1 - HALF_H);
   localparam logic signed [NUM_W-1:0]  Y_OFF  = NUM_W'(HALF_H);
   localparam logic [Q_W-1:0]           POS_MAX = Q_W'(32767);
   localparam logic [Q_W-1:0]           NEG_MAX = Q_W'(32768);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_R0_A = 4'd0,
      REG_R0_B = 4'd1,
      REG_R1_A = 4'd2,
      REG_R1_B = 4'd3,
      REG_R2_A = 4'd4,
      REG_R2_B = 4'd5,
      REG_R3_A = 4'd6,
      REG_R3_B = 4'd7
   } reg_index_type;

   typedef struct packed {
      logic vis;
      logic neg_x;
      logic neg_y;
      logic big_x;
      logic big_y;
   } flags_type;

endpackage

// File: rtl/pws_req_if.sv
// Input channel: one world-space point per transfer.
// Depends on pws_pkg.
interface pws_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [pws_pkg::COORD_W-1:0] world_x;
   logic signed [pws_pkg::COORD_W-1:0] world_y;
   logic signed [pws_pkg::COORD_W-1:0] world_z;
   modport source (output valid, world_x, world_y, world_z, input ready);
   modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

// File: rtl/pws_rsp_if.sv
// Result channel: visibility flag and pixel coordinates per transfer.
// Depends on pws_pkg.
interface pws_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             visible;
   logic signed [pws_pkg::PIX_W-1:0] screen_x;
   logic signed [pws_pkg::PIX_W-1:0] screen_y;
   modport source (output valid, visible, screen_x, screen_y, input ready);
   modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

// File: rtl/pws_div_step.sv
// One restoring division step: one quotient bit per pipeline stage.
// Depends on pws_pkg.
module pws_div_step (
   input  logic                        clock,
   input  logic                        en,
   input  logic [pws_pkg::REM_W-1:0]   d15,
   input  logic [pws_pkg::REM_W-1:0]   rem_in,
   input  logic [pws_pkg::Q_W-1:0]     q_in,
   output logic [pws_pkg::REM_W-1:0]   rem_out,
   output logic [pws_pkg::Q_W-1:0]     q_out
);
   logic [pws_pkg::REM_W-1:0] rem_ff, rem_in_v, diff;
   logic [pws_pkg::Q_W-1:0]   q_ff, q_in_v;
   logic                      ge;

   always_comb begin
      ge       = rem_in >= d15;
      diff     = ge ? rem_in - d15 : rem_in;
      rem_in_v = {diff[pws_pkg::REM_W-2:0], 1'b0};
      q_in_v   = {q_in[pws_pkg::Q_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in_v;
         q_ff   <= q_in_v;
      end
   end

   assign rem_out = rem_ff;
   assign q_out   = q_ff;
endmodule

// File: rtl/perspective_world_to_screen_unit.sv
// Top level of the perspective world-to-screen unit: matrix registers,
// transform, viewport mapping and pipelined divide. Depends on pws_pkg,
// pws_req_if, pws_rsp_if and pws_div_step.
//
// Accepts one point per clock unless a stall at the output holds the pipeline, and returns
// one result per point, in order. There are 21 register stages: products, row sums, viewport
// numerators, range check, sixteen one-bit divide stages and the output register. A full
// stage holds while its successor holds, so a stall at the output only stops the stages that
// hold data. Matrix writes take effect at once and belong in idle time.
module perspective_world_to_screen_unit (
   input  logic                               clock,
   input  logic                               reset,
   pws_req_if.sink                            req_if,
   pws_rsp_if.source                          rsp_if,
   input  logic                               csr_we,
   input  logic [pws_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pws_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   localparam int N = pws_pkg::STAGES;
   localparam int DS = pws_pkg::DIV_STEPS;

   // matrix: rows 0, 1 and 3 (row 2 is never read)
   logic [pws_pkg::CSR_DATA_W-1:0] mat_ff [pws_pkg::MAT_REGS];
   logic signed [pws_pkg::COORD_W-1:0] ent [3][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[0] <= 64'd65536;
         mat_ff[1] <= 64'd0;
         mat_ff[2] <= 64'd65536 << 32;
         mat_ff[3] <= 64'd0;
         mat_ff[4] <= 64'd0;
         mat_ff[5] <= 64'd65536 << 32;
      end else if (csr_we) begin
         unique case (csr_index)
            pws_pkg::REG_R0_A: mat_ff[0] <= csr_wdata;
            pws_pkg::REG_R0_B: mat_ff[1] <= csr_wdata;
            pws_pkg::REG_R1_A: mat_ff[2] <= csr_wdata;
            pws_pkg::REG_R1_B: mat_ff[3] <= csr_wdata;
            pws_pkg::REG_R3_A: mat_ff[4] <= csr_wdata;
            pws_pkg::REG_R3_B: mat_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         ent[r][0] = mat_ff[2*r][31:0];
         ent[r][1] = mat_ff[2*r][63:32];
         ent[r][2] = mat_ff[2*r+1][31:0];
         ent[r][3] = mat_ff[2*r+1][63:32];
      end
   end

   // stage control
   logic [N-1:0] v_ff;
   logic [N-1:0] v_in;
   logic [N:0]   en;

   always_comb begin
      en[N] = rsp_if.ready;
      for (int i = N - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   always_comb begin
      v_in[0] = en[0] ? req_if.valid : v_ff[0];
      for (int i = 1; i < N; i++) begin
         v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_if.ready = en[0];

   // stage 0: products
   logic signed [pws_pkg::PROD_W-1:0] prod_ff [9];
   logic signed [pws_pkg::PROD_W-1:0] prod_in [9];
   logic signed [pws_pkg::COORD_W-1:0] pt [3];

   always_comb begin
      pt[0] = req_if.world_x;
      pt[1] = req_if.world_y;
      pt[2] = req_if.world_z;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[3*r+c] = pws_pkg::PROD_W'(pt[c]) * pws_pkg::PROD_W'(ent[r][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
      end
   end

   // stage 1: row sums (products floored to Q16.16)
   logic signed [pws_pkg::CLIP_W-1:0] clip_ff [3];
   logic signed [pws_pkg::CLIP_W-1:0] clip_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         clip_in[r] = pws_pkg::CLIP_W'(prod_ff[3*r]   >>> 16)
                    + pws_pkg::CLIP_W'(prod_ff[3*r+1] >>> 16)
                    + pws_pkg::CLIP_W'(prod_ff[3*r+2] >>> 16)
                    + pws_pkg::CLIP_W'(ent[r][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         clip_ff <= clip_in;
      end
   end

   // stage 2: viewport numerators
   logic signed [pws_pkg::NUM_W-1:0] cw_s, num_x, num_y;
   logic [pws_pkg::NUM_W-1:0] mag_x, mag_y;
   logic [pws_pkg::REM_W-1:0] magx_ff, magy_ff, d15_2_in, d15_2_ff;
   logic [pws_pkg::REM_W-1:0] d16;
   pws_pkg::flags_type        fl2_ff, fl2_in;

   always_comb begin
      cw_s  = pws_pkg::NUM_W'(clip_ff[2]);
      num_x = pws_pkg::NUM_W'(clip_ff[0]) * pws_pkg::X_MUL + cw_s * pws_pkg::X_OFF;
      num_y = pws_pkg::NUM_W'(clip_ff[1]) * pws_pkg::Y_MUL + cw_s * pws_pkg::Y_OFF;
      mag_x = num_x[pws_pkg::NUM_W-1] ? -num_x : num_x;
      mag_y = num_y[pws_pkg::NUM_W-1] ? -num_y : num_y;
      d15_2_in = pws_pkg::REM_W'({clip_ff[2][pws_pkg::CLIP_W-2:0], 15'd0});
      fl2_in = '{vis:   clip_ff[2] >= pws_pkg::W_VISIBLE_MIN,
                 neg_x: num_x[pws_pkg::NUM_W-1],
                 neg_y: num_y[pws_pkg::NUM_W-1],
                 big_x: 1'b0,
                 big_y: 1'b0};
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         magx_ff  <= pws_pkg::REM_W'(mag_x);
         magy_ff  <= pws_pkg::REM_W'(mag_y);
         d15_2_ff <= d15_2_in;
         fl2_ff   <= fl2_in;
      end
   end

   // stage 3: quotient range check (quotient of 2^16 or more saturates)
   logic [pws_pkg::REM_W-1:0] remx_ff, remy_ff, d15_3_ff;
   pws_pkg::flags_type        fl3_ff, fl3_in;

   always_comb begin
      d16    = {d15_2_ff[pws_pkg::REM_W-2:0], 1'b0};
      fl3_in = fl2_ff;
      fl3_in.big_x = magx_ff >= d16;
      fl3_in.big_y = magy_ff >= d16;
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         remx_ff  <= magx_ff;
         remy_ff  <= magy_ff;
         d15_3_ff <= d15_2_ff;
         fl3_ff   <= fl3_in;
      end
   end

   // stages 4 .. 4+DS-1: divide
   logic [pws_pkg::REM_W-1:0] rx [DS+1];
   logic [pws_pkg::REM_W-1:0] ry [DS+1];
   logic [pws_pkg::Q_W-1:0]   qx [DS+1];
   logic [pws_pkg::Q_W-1:0]   qy [DS+1];
   logic [pws_pkg::REM_W-1:0] dp [DS+1];
   pws_pkg::flags_type        fp [DS+1];
   logic [pws_pkg::REM_W-1:0] dp_ff [DS];
   pws_pkg::flags_type        fp_ff [DS];

   assign rx[0] = remx_ff;
   assign ry[0] = remy_ff;
   assign qx[0] = '0;
   assign qy[0] = '0;
   assign dp[0] = d15_3_ff;
   assign fp[0] = fl3_ff;

   for (genvar k = 0; k < DS; k++) begin : g_div
      pws_div_step u_step_x (
         .clock   (clock),
         .en      (en[4+k]),
         .d15     (dp[k]),
         .rem_in  (rx[k]),
         .q_in    (qx[k]),
         .rem_out (rx[k+1]),
         .q_out   (qx[k+1])
      );
      pws_div_step u_step_y (
         .clock   (clock),
         .en      (en[4+k]),
         .d15     (dp[k]),
         .rem_in  (ry[k]),
         .q_in    (qy[k]),
         .rem_out (ry[k+1]),
         .q_out   (qy[k+1])
      );
      always_ff @(posedge clock) begin
         if (en[4+k]) begin
            dp_ff[k] <= dp[k];
            fp_ff[k] <= fp[k];
         end
      end
      assign dp[k+1] = dp_ff[k];
      assign fp[k+1] = fp_ff[k];
   end

   // last stage: sign, saturation, output register
   logic                             vis_ff;
   logic signed [pws_pkg::PIX_W-1:0] sx_ff, sy_ff, sx_in, sy_in;
   pws_pkg::flags_type               ff;
   logic [pws_pkg::Q_W-1:0]          qxf, qyf;

   always_comb begin
      ff  = fp[DS];
      qxf = qx[DS];
      qyf = qy[DS];
      if (!ff.vis) begin
         sx_in = '0;
      end else if (ff.neg_x) begin
         sx_in = (ff.big_x || qxf > pws_pkg::NEG_MAX) ? pws_pkg::NEG_MAX : -qxf;
      end else begin
         sx_in = (ff.big_x || qxf > pws_pkg::POS_MAX) ? pws_pkg::POS_MAX : qxf;
      end
      if (!ff.vis) begin
         sy_in = '0;
      end else if (ff.neg_y) begin
         sy_in = (ff.big_y || qyf > pws_pkg::NEG_MAX) ? pws_pkg::NEG_MAX : -qyf;
      end else begin
         sy_in = (ff.big_y || qyf > pws_pkg::POS_MAX) ? pws_pkg::POS_MAX : qyf;
      end
   end

   always_ff @(posedge clock) begin
      if (en[N-1]) begin
         vis_ff <= ff.vis;
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
      end
   end

   assign rsp_if.valid    = v_ff[N-1];
   assign rsp_if.visible  = vis_ff;
   assign rsp_if.screen_x = sx_ff;
   assign rsp_if.screen_y = sy_ff;

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.visible |-> rsp_if.screen_x == '0 && rsp_if.screen_y == '0)
      else $error("hidden point with non-zero pixels");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !v_ff[N-1] |-> req_if.ready)
      else $error("input stalled with empty output stage");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(sx_ff) && $stable(sy_ff))
      else $error("stalled result changed");
endmodule

// File: test/tb_perspective_world_to_screen_unit.sv
// Self-checking testbench for perspective_world_to_screen_unit: directed table then random
// points over several matrix settings, checked in order against a built-in projection model.
// Depends on pws_pkg, pws_req_if, pws_rsp_if and the unit itself.
module tb_perspective_world_to_screen_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 30;

   typedef struct {
      logic                             vis;
      logic signed [pws_pkg::PIX_W-1:0] sx;
      logic signed [pws_pkg::PIX_W-1:0] sy;
   } pixel_type;

   typedef struct {
      logic signed [pws_pkg::COORD_W-1:0] x;
      logic signed [pws_pkg::COORD_W-1:0] y;
      logic signed [pws_pkg::COORD_W-1:0] z;
      bit                                 typed;
      pixel_type                          pix;
   } point_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [pws_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pws_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   pws_req_if req_if ();
   pws_rsp_if rsp_if ();

   perspective_world_to_screen_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   logic [63:0] matrix_q [8];
   pixel_type pixel_q [$];
   int mismatches = 0;
   int cycles = 0;
   bit quiet = 0;
   bit hold_req = 0;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** perspective_world_to_screen_unit: FAILED **");
         $finish;
      end
   end

   function automatic longint mat_entry(int r, int c);
      logic [63:0] rv;
      logic signed [31:0] half;
      rv = matrix_q[2*r + c/2];
      half = (c % 2) ? rv[63:32] : rv[31:0];
      return longint'(half);
   endfunction

   function automatic longint clip_row(int r, longint x, longint y, longint z);
      return ((x * mat_entry(r, 0)) >>> 16) + ((y * mat_entry(r, 1)) >>> 16) +
             ((z * mat_entry(r, 2)) >>> 16) + mat_entry(r, 3);
   endfunction

   function automatic logic signed [pws_pkg::PIX_W-1:0] clamp16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   function automatic pixel_type project_point(logic signed [31:0] px,
                                               logic signed [31:0] py,
                                               logic signed [31:0] pz);
      pixel_type p;
      longint cx, cy, cw, hw, hh;
      cx = clip_row(0, px, py, pz);
      cy = clip_row(1, px, py, pz);
      cw = clip_row(3, px, py, pz);
      hw = pws_pkg::SCREEN_WIDTH / 2;
      hh = pws_pkg::SCREEN_HEIGHT / 2;
      p = '{1'b0, '0, '0};
      if (cw >= 6554) begin
         p.vis = 1'b1;
         p.sx = clamp16((cx * (hw + 1) + hw * cw) / cw);
         p.sy = clamp16((cy * (1 - hh) + hh * cw) / cw);
      end
      return p;
   endfunction

   task automatic csr_write(int idx, logic [63:0] data);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx[pws_pkg::CSR_IDX_W-1:0];
      csr_wdata = data;
      if (idx < 8) matrix_q[idx] = data;
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic wait_drain();
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_point(point_row_type row);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid = 0;
         end
      end
      @(negedge clock);
      req_if.valid = 1;
      req_if.world_x = row.x;
      req_if.world_y = row.y;
      req_if.world_z = row.z;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pixel_q.push_back(row.typed ? row.pix : project_point(row.x, row.y, row.z));
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_if.valid = 0;
   endtask

   // Receiver: random stalls, one long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      bit hold_done;
      stall_left = 0;
      hold_left = 0;
      hold_done = 0;
      rsp_if.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = 150;
         end
         if (reset) rsp_if.ready = 0;
         else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready = 0;
         end else if (quiet) rsp_if.ready = 1;
         else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready = 0;
         end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_if.ready = 0;
         end else rsp_if.ready = 1;
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pixel_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer: vis=%0b x=%0d y=%0d",
                                           rsp_if.visible, rsp_if.screen_x, rsp_if.screen_y);
         end else begin
            want = pixel_q.pop_front();
            if (rsp_if.visible !== want.vis || rsp_if.screen_x !== want.sx ||
                rsp_if.screen_y !== want.sy) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected vis=%0b x=%0d y=%0d, got vis=%0b x=%0d y=%0d",
                           want.vis, want.sx, want.sy,
                           rsp_if.visible, rsp_if.screen_x, rsp_if.screen_y);
            end
         end
      end
   end

   function automatic logic [31:0] rand_entry();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'h0;
         2: return 32'h10000;
         default: return 32'($signed($urandom_range(0, 262144)) - 131072);
      endcase
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
      endcase
   endfunction

   task automatic random_matrix(int style);
      logic [31:0] w3;
      for (int i = 0; i < 6; i++) csr_write(i, {rand_entry(), rand_entry()});
      case (style)
         0: csr_write(pws_pkg::REG_R3_A, 64'hFFFF_FFFF_FFFF_FFFF);
         1: csr_write(pws_pkg::REG_R3_A, 64'h7FFF_FFFF_8000_0000);
         default: csr_write(pws_pkg::REG_R3_A, {32'($urandom_range(0, 8192)),
                                                32'($urandom_range(0, 8192))});
      endcase
      w3 = (style == 1) ? 32'h7FFF_FFFF : 32'($urandom_range(1000, 4000000));
      csr_write(pws_pkg::REG_R3_B, {w3, rand_entry()});
   endtask

   point_row_type directed [9];
   point_row_type row;

   initial begin
      req_if.valid = 0;
      req_if.world_x = '0;
      req_if.world_y = '0;
      req_if.world_z = '0;
      matrix_q = '{64'd65536, 64'd0, 64'd65536 << 32, 64'd0,
                   64'd0, 64'd65536, 64'd0, 64'd65536 << 32};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      directed = '{
         '{32'sd0, 32'sd0, 32'sd0, 1, '{1'b1, 16'sd960, 16'sd540}},
         '{32'sd65536, 32'sd0, 32'sd0, 1, '{1'b1, 16'sd1921, 16'sd540}},
         '{32'sd0, 32'sd65536, 32'sd0, 1, '{1'b1, 16'sd960, 16'sd1}},
         '{32'sh8000_0000, 32'sd0, 32'sd0, 1, '{1'b1, -16'sd32768, 16'sd540}},
         '{32'sd0, 32'sh8000_0000, 32'sd0, 1, '{1'b1, 16'sd960, 16'sd32767}},
         '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, '{1'b0, '0, '0}},
         '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, '{1'b0, '0, '0}},
         '{-32'sd1, -32'sd1, -32'sd1, 0, '{1'b0, '0, '0}},
         '{32'sd1, 32'sd1, 32'sd1, 0, '{1'b0, '0, '0}}
      };
      foreach (directed[i]) send_point(directed[i]);
      end_burst();
      wait_drain();

      // w just below, then at, the visibility threshold
      csr_write(pws_pkg::REG_R3_B, 64'd6553 << 32);
      csr_write(15, 64'hDEAD_BEEF_0000_0001);
      row = '{32'sd65536, 32'sd65536, 32'sd0, 1, '{1'b0, '0, '0}};
      send_point(row);
      row = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd7, 1, '{1'b0, '0, '0}};
      send_point(row);
      end_burst();
      wait_drain();
      csr_write(pws_pkg::REG_R3_B, 64'd6554 << 32);
      csr_write(8, 64'h0);
      for (int i = 0; i < 4; i++) begin
         row = '{$signed(rand_coord()), $signed(rand_coord()), $signed(rand_coord()),
                 0, '{1'b0, '0, '0}};
         send_point(row);
      end
      row = '{32'sd0, 32'sd0, 32'sd0, 0, '{1'b0, '0, '0}};
      send_point(row);
      end_burst();
      wait_drain();

      for (int ph = 0; ph < 7; ph++) begin
         random_matrix(ph == 0 ? 0 : (ph == 1 ? 1 : 2));
         if (ph == 6) quiet = 1;
         for (int n = 0; n < 90; n++) begin
            if (ph == 2 && n == 5) hold_req = 1;
            if (ph == 3 && n == 45) begin
               end_burst();
               wait_drain();
            end
            row = '{$signed(rand_coord()), $signed(rand_coord()), $signed(rand_coord()),
                    0, '{1'b0, '0, '0}};
            send_point(row);
         end
         end_burst();
         wait_drain();
      end

      if (mismatches == 0 && pixel_q.size() == 0)
         $display("** perspective_world_to_screen_unit: PASSED **");
      else
         $display("** perspective_world_to_screen_unit: FAILED **");
      $finish;
   end
endmodule
